// ----- rtl/sfs_pkg.sv -----
// Shared sizes, limits and memory write request types for the site frequency spectrum block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package sfs_pkg;

   localparam int MAX_SITES      = 1024;
   localparam int MAX_HAPLOTYPES = 64;

   localparam int SITE_AW      = $clog2(MAX_SITES);
   localparam int SITE_PW      = SITE_AW + 1;
   localparam int CLASS_W      = $clog2(MAX_HAPLOTYPES);
   localparam int HAP_W        = CLASS_W + 1;
   localparam int SITE_COUNT_W = 7;
   localparam int COUNT_W      = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = 11'd2047;
   localparam logic [COUNT_W-1:0] SITE_COUNT_MAX = 11'd127;

   typedef struct packed {
      logic                    en;
      logic [SITE_AW-1:0]      addr;
      logic [SITE_COUNT_W-1:0] data;
   } count_wr_type;

   typedef struct packed {
      logic               en;
      logic [CLASS_W-1:0] addr;
      logic [COUNT_W-1:0] data;
   } spec_wr_type;

endpackage

// ----- rtl/sfs_sat_add.sv -----
// Shared saturating adder used for site counts, histogram bins and folding.
// Depends on sfs_pkg for the count width.
`timescale 1ns / 1ps

module sfs_sat_add (
   input  logic [sfs_pkg::COUNT_W-1:0] a,
   input  logic [sfs_pkg::COUNT_W-1:0] b,
   input  logic [sfs_pkg::COUNT_W-1:0] limit,
   output logic [sfs_pkg::COUNT_W-1:0] y
);

   logic [sfs_pkg::COUNT_W:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};
   assign y   = (sum > {1'b0, limit}) ? limit : sum[sfs_pkg::COUNT_W-1:0];

endmodule

// ----- rtl/sfs_count_store.sv -----
// Per-site derived allele count memory: one write port, one registered read port.
// Depends on sfs_pkg for sizes and the write request type.
`timescale 1ns / 1ps

module sfs_count_store (
   input  logic                              clock,
   input  logic [sfs_pkg::SITE_AW-1:0]       rd_addr,
   input  sfs_pkg::count_wr_type             wr,
   output logic [sfs_pkg::SITE_COUNT_W-1:0]  rd_data
);

   logic [sfs_pkg::SITE_COUNT_W-1:0] mem [sfs_pkg::MAX_SITES];
   logic [sfs_pkg::SITE_COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sfs_spectrum_store.sv -----
// Spectrum bin memory with per-entry valid bits; an entry not valid reads as zero.
// Depends on sfs_pkg for sizes and the write request type.
`timescale 1ns / 1ps

module sfs_spectrum_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [sfs_pkg::CLASS_W-1:0]   rd_addr,
   input  sfs_pkg::spec_wr_type          wr,
   output logic [sfs_pkg::COUNT_W-1:0]   rd_data
);

   logic [sfs_pkg::COUNT_W-1:0]        mem [sfs_pkg::MAX_HAPLOTYPES];
   logic [sfs_pkg::MAX_HAPLOTYPES-1:0] valid_ff;
   logic [sfs_pkg::MAX_HAPLOTYPES-1:0] valid_in;
   logic [sfs_pkg::COUNT_W-1:0]        rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/site_frequency_spectrum.sv -----
// Site frequency spectrum of a haplotype sample: sequencer, count and spectrum stores.
// Depends on sfs_pkg, sfs_sat_add, sfs_count_store and sfs_spectrum_store.
//
// Input channel req_*: one allele bit per item, with line and sample end marks.
// An item is taken when req_valid is high and req_stall is low. Each bit is
// a read of the site count memory, then the incremented write back. The bit that
// ends a sample starts the spectrum pass, during which req_stall stays high: per
// site in use the histogram reads the count and the bin, then writes the bin;
// when folding, per folded class pair it reads the mirror bin, holds it and
// writes the sum; then each class is read and emitted, held while rsp_stall is high.
// All of it runs through one saturating adder and single-port memory reads.
// Result channel rsp_*: classes 1..n-1 (or 1..n/2 folded) in order, the final
// one flagged by rsp_last_class. While rsp_stall is high the result holds.
// Samples with fewer than two lines give no results.
// csr_wr_en with csr_wr_data sets the fold enable; write it only while idle.
// Reset (synchronous) empties the sample state and clears fold enable. The
// count memory needs no clearing: the first line of each sample overwrites it.
`timescale 1ns / 1ps

module site_frequency_spectrum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_allele_bit,
   input  logic                           req_last_in_line,
   input  logic                           req_last_in_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sfs_pkg::CLASS_W-1:0]    rsp_class_index,
   output logic [sfs_pkg::COUNT_W-1:0]    rsp_class_count,
   output logic                           rsp_last_class,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_UPD   = 4'd1;
   localparam logic [3:0] ST_H_RD  = 4'd2;
   localparam logic [3:0] ST_H_SP  = 4'd3;
   localparam logic [3:0] ST_H_WR  = 4'd4;
   localparam logic [3:0] ST_F_RD  = 4'd5;
   localparam logic [3:0] ST_F_HI  = 4'd6;
   localparam logic [3:0] ST_F_WR  = 4'd7;
   localparam logic [3:0] ST_E_RD  = 4'd8;
   localparam logic [3:0] ST_E_OUT = 4'd9;

   logic [3:0]                        state_ff, state_in;
   logic [sfs_pkg::SITE_PW-1:0]       sp_ff, sp_in;
   logic [sfs_pkg::SITE_PW-1:0]       siu_ff, siu_in;
   logic [sfs_pkg::HAP_W-1:0]         hc_ff, hc_in;
   logic                              fold_ff, fold_in;
   logic                              end_ff, end_in;
   logic                              pend_we_ff, pend_we_in;
   logic                              pend_first_ff, pend_first_in;
   logic                              pend_bit_ff, pend_bit_in;
   logic [sfs_pkg::SITE_AW-1:0]       pend_addr_ff, pend_addr_in;
   logic [sfs_pkg::SITE_PW-1:0]       idx_ff, idx_in;
   logic                              cls_ok_ff, cls_ok_in;
   logic [sfs_pkg::CLASS_W-1:0]       cls_ff, cls_in;
   logic [sfs_pkg::CLASS_W-1:0]       k_ff, k_in;
   logic [sfs_pkg::CLASS_W-1:0]       last_ff, last_in;
   logic [sfs_pkg::COUNT_W-1:0]       hold_ff, hold_in;

   logic                              req_accept;
   logic                              in_range;
   logic                              go_emit;
   logic                              do_clear;
   logic [sfs_pkg::CLASS_W-1:0]       last_calc;
   logic [sfs_pkg::HAP_W-1:0]         n_minus_1;
   logic [sfs_pkg::HAP_W-1:0]         mirror;
   logic [sfs_pkg::HAP_W-1:0]         k_next;
   logic [sfs_pkg::SITE_PW-1:0]       idx_next;

   logic [sfs_pkg::SITE_AW-1:0]       cnt_rd_addr;
   logic [sfs_pkg::SITE_COUNT_W-1:0]  cnt_rd;
   sfs_pkg::count_wr_type             cnt_wr;
   logic [sfs_pkg::CLASS_W-1:0]       spec_rd_addr;
   logic [sfs_pkg::COUNT_W-1:0]       spec_rd;
   sfs_pkg::spec_wr_type              spec_wr;
   logic                              spec_clear;

   logic [sfs_pkg::COUNT_W-1:0]       alu_a, alu_b, alu_lim, alu_y;

   sfs_sat_add u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .limit (alu_lim),
      .y     (alu_y)
   );

   sfs_count_store u_counts (
      .clock   (clock),
      .rd_addr (cnt_rd_addr),
      .wr      (cnt_wr),
      .rd_data (cnt_rd)
   );

   sfs_spectrum_store u_spectrum (
      .clock   (clock),
      .reset   (reset),
      .clear   (spec_clear),
      .rd_addr (spec_rd_addr),
      .wr      (spec_wr),
      .rd_data (spec_rd)
   );

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign in_range  = !hc_ff[sfs_pkg::HAP_W-1] && !sp_ff[sfs_pkg::SITE_PW-1];
   assign n_minus_1 = hc_ff - {{(sfs_pkg::HAP_W-1){1'b0}}, 1'b1};
   assign last_calc = (hc_ff < 7'd2) ? '0 :
                      fold_ff ? hc_ff[sfs_pkg::HAP_W-1:1] : n_minus_1[sfs_pkg::CLASS_W-1:0];
   assign mirror    = hc_ff - {1'b0, k_ff};
   assign k_next    = {1'b0, k_ff} + {{(sfs_pkg::HAP_W-1){1'b0}}, 1'b1};
   assign idx_next  = idx_ff + {{(sfs_pkg::SITE_PW-1){1'b0}}, 1'b1};

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      siu_in        = siu_ff;
      hc_in         = hc_ff;
      fold_in       = csr_wr_en ? csr_wr_data : fold_ff;
      end_in        = end_ff;
      pend_we_in    = pend_we_ff;
      pend_first_in = pend_first_ff;
      pend_bit_in   = pend_bit_ff;
      pend_addr_in  = pend_addr_ff;
      idx_in        = idx_ff;
      cls_ok_in     = cls_ok_ff;
      cls_in        = cls_ff;
      k_in          = k_ff;
      last_in       = last_ff;
      hold_in       = hold_ff;
      go_emit       = 1'b0;
      do_clear      = 1'b0;
      cnt_rd_addr   = sp_ff[sfs_pkg::SITE_AW-1:0];
      cnt_wr        = '0;
      spec_rd_addr  = k_ff;
      spec_wr       = '0;
      spec_clear    = 1'b0;
      alu_a         = spec_rd;
      alu_b         = {{(sfs_pkg::COUNT_W-1){1'b0}}, 1'b1};
      alu_lim       = sfs_pkg::COUNT_MAX;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (in_range && (hc_ff == '0)) begin
                  siu_in = sp_ff + {{(sfs_pkg::SITE_PW-1){1'b0}}, 1'b1};
               end
               pend_we_in    = in_range && ((hc_ff == '0) ||
                               ((sp_ff < siu_ff) && req_allele_bit));
               pend_first_in = (hc_ff == '0);
               pend_bit_in   = req_allele_bit;
               pend_addr_in  = sp_ff[sfs_pkg::SITE_AW-1:0];
               end_in        = req_last_in_sample;
               if (req_last_in_line || req_last_in_sample) begin
                  sp_in = '0;
                  if (!hc_ff[sfs_pkg::HAP_W-1]) begin
                     hc_in = hc_ff + {{(sfs_pkg::HAP_W-1){1'b0}}, 1'b1};
                  end
               end else if (!sp_ff[sfs_pkg::SITE_PW-1]) begin
                  sp_in = sp_ff + {{(sfs_pkg::SITE_PW-1){1'b0}}, 1'b1};
               end
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            alu_a       = {{(sfs_pkg::COUNT_W-sfs_pkg::SITE_COUNT_W){1'b0}}, cnt_rd};
            alu_b       = {{(sfs_pkg::COUNT_W-1){1'b0}}, pend_bit_ff};
            alu_lim     = sfs_pkg::SITE_COUNT_MAX;
            cnt_wr.en   = pend_we_ff;
            cnt_wr.addr = pend_addr_ff;
            cnt_wr.data = pend_first_ff ?
                          {{(sfs_pkg::SITE_COUNT_W-1){1'b0}}, pend_bit_ff} :
                          alu_y[sfs_pkg::SITE_COUNT_W-1:0];
            if (end_ff) begin
               idx_in   = '0;
               state_in = ST_H_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_H_RD: begin
            cnt_rd_addr = idx_ff[sfs_pkg::SITE_AW-1:0];
            state_in    = ST_H_SP;
         end
         ST_H_SP: begin
            cls_ok_in    = (cnt_rd != '0) && (cnt_rd < hc_ff) &&
                           (cnt_rd < 7'(sfs_pkg::MAX_HAPLOTYPES));
            cls_in       = cnt_rd[sfs_pkg::CLASS_W-1:0];
            spec_rd_addr = cnt_rd[sfs_pkg::CLASS_W-1:0];
            state_in     = ST_H_WR;
         end
         ST_H_WR: begin
            spec_wr.en   = cls_ok_ff;
            spec_wr.addr = cls_ff;
            spec_wr.data = alu_y;
            if (idx_next == siu_ff) begin
               if (fold_ff && (hc_ff > 7'd2)) begin
                  k_in     = 6'd1;
                  state_in = ST_F_RD;
               end else begin
                  go_emit = 1'b1;
               end
            end else begin
               idx_in   = idx_next;
               state_in = ST_H_RD;
            end
         end
         ST_F_RD: begin
            spec_rd_addr = mirror[sfs_pkg::CLASS_W-1:0];
            state_in     = ST_F_HI;
         end
         ST_F_HI: begin
            hold_in  = spec_rd;
            state_in = ST_F_WR;
         end
         ST_F_WR: begin
            alu_b        = hold_ff;
            spec_wr.en   = 1'b1;
            spec_wr.addr = k_ff;
            spec_wr.data = alu_y;
            if ({k_next, 1'b0} < {1'b0, hc_ff}) begin
               k_in     = k_next[sfs_pkg::CLASS_W-1:0];
               state_in = ST_F_RD;
            end else begin
               go_emit = 1'b1;
            end
         end
         ST_E_RD: begin
            state_in = ST_E_OUT;
         end
         ST_E_OUT: begin
            if (!rsp_stall) begin
               if (k_ff == last_ff) begin
                  do_clear = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_next[sfs_pkg::CLASS_W-1:0];
                  state_in = ST_E_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (go_emit) begin
         k_in    = 6'd1;
         last_in = last_calc;
         if (last_calc == '0) begin
            do_clear = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_E_RD;
         end
      end

      if (do_clear) begin
         sp_in      = '0;
         siu_in     = '0;
         hc_in      = '0;
         spec_clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         siu_ff   <= '0;
         hc_ff    <= '0;
         fold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         siu_ff   <= siu_in;
         hc_ff    <= hc_in;
         fold_ff  <= fold_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff        <= end_in;
      pend_we_ff    <= pend_we_in;
      pend_first_ff <= pend_first_in;
      pend_bit_ff   <= pend_bit_in;
      pend_addr_ff  <= pend_addr_in;
      idx_ff        <= idx_in;
      cls_ok_ff     <= cls_ok_in;
      cls_ff        <= cls_in;
      k_ff          <= k_in;
      last_ff       <= last_in;
      hold_ff       <= hold_in;
   end

   assign rsp_valid       = (state_ff == ST_E_OUT);
   assign rsp_class_index = k_ff;
   assign rsp_class_count = spec_rd;
   assign rsp_last_class  = (k_ff == last_ff);

endmodule

// ----- rtl/sfs_checker.sv -----
// Port-level checks for the site frequency spectrum block, bound to the top level.
// Depends on sfs_pkg for field widths and on site_frequency_spectrum for the bind.
`timescale 1ns / 1ps

module sfs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [sfs_pkg::CLASS_W-1:0]    rsp_class_index,
   input logic [sfs_pkg::COUNT_W-1:0]    rsp_class_count,
   input logic                           rsp_last_class
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_class_index) &&
         $stable(rsp_class_count) && $stable(rsp_last_class))
      else $error("stalled rsp item changed");

   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall && (rsp_class_index != '0))
      else $error("rsp item while input open or class zero");

   a_class_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_class |=> ##1
         rsp_valid && (rsp_class_index == 6'($past(rsp_class_index, 2) + 6'd1)))
      else $error("classes not emitted in order");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("req taken without busy cycle");

endmodule

bind site_frequency_spectrum sfs_checker u_sfs_checker (.*);

// ----- test/tb_site_frequency_spectrum.sv -----
// Self-checking testbench for site_frequency_spectrum: haplotype bits in, spectrum classes out.
// Depends on sfs_pkg and the RTL top; a scoreboard class predicts each class from accepted bits.
`timescale 1ns / 1ps

module tb_site_frequency_spectrum;

   localparam int SETTLE_CYCLES  = 3 * sfs_pkg::MAX_SITES + 3 * sfs_pkg::MAX_HAPLOTYPES + 64;
   localparam int WATCHDOG_LIMIT = 30000;
   localparam int ITEMS_PER_PHASE = 50;

   class sfs_tally;
      typedef struct {
         logic [sfs_pkg::CLASS_W-1:0] index;
         logic [sfs_pkg::COUNT_W-1:0] count;
         logic                        last;
      } spectrum_entry_type;

      int unsigned        derived_per_site [sfs_pkg::MAX_SITES];
      int unsigned        hist [sfs_pkg::MAX_HAPLOTYPES];
      int unsigned        site_ptr;
      int unsigned        sites_used;
      int unsigned        lines;
      bit                 fold;
      spectrum_entry_type pending [$];
      int unsigned        mismatches;

      function new();
         clear_sample();
         fold = 1'b0;
         mismatches = 0;
      endfunction

      function void clear_sample();
         foreach (derived_per_site[i]) derived_per_site[i] = 0;
         foreach (hist[i]) hist[i] = 0;
         site_ptr = 0;
         sites_used = 0;
         lines = 0;
      endfunction

      function void note_item(input bit allele, input bit eol, input bit eos);
         int unsigned        n;
         int unsigned        c;
         int unsigned        sum;
         int unsigned        top;
         spectrum_entry_type e;
         if (lines < sfs_pkg::MAX_HAPLOTYPES && site_ptr < sfs_pkg::MAX_SITES) begin
            if (lines == 0) sites_used = site_ptr + 1;
            if (site_ptr < sites_used && allele &&
                derived_per_site[site_ptr] < sfs_pkg::SITE_COUNT_MAX)
               derived_per_site[site_ptr]++;
         end
         if (eol || eos) begin
            site_ptr = 0;
            if (lines < sfs_pkg::MAX_HAPLOTYPES) lines++;
         end else if (site_ptr < sfs_pkg::MAX_SITES) begin
            site_ptr++;
         end
         if (!eos) return;

         n = lines;
         for (int unsigned i = 0; i < sites_used && i < sfs_pkg::MAX_SITES; i++) begin
            c = derived_per_site[i];
            if (c >= 1 && c < n && c < sfs_pkg::MAX_HAPLOTYPES && hist[c] < sfs_pkg::COUNT_MAX)
               hist[c]++;
         end
         if (fold) begin
            for (int unsigned i = 1; i < n - i && (n - i) < sfs_pkg::MAX_HAPLOTYPES; i++) begin
               sum = hist[i] + hist[n - i];
               hist[i] = (sum > sfs_pkg::COUNT_MAX) ? sfs_pkg::COUNT_MAX : sum;
            end
            top = n / 2;
         end else begin
            top = (n >= 1) ? n - 1 : 0;
         end
         if (n < 2) top = 0;
         if (top > sfs_pkg::MAX_HAPLOTYPES - 1) top = sfs_pkg::MAX_HAPLOTYPES - 1;
         for (int unsigned k = 1; k <= top; k++) begin
            e.index = 6'(k);
            e.count = 11'(hist[k]);
            e.last  = (k == top);
            pending.push_back(e);
         end
         clear_sample();
      endfunction

      function void check_class(input logic [sfs_pkg::CLASS_W-1:0] index,
                                input logic [sfs_pkg::COUNT_W-1:0] count,
                                input logic last);
         spectrum_entry_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected class: index %0d count %0d last %0d", index, count, last);
            return;
         end
         e = pending.pop_front();
         if (index !== e.index || count !== e.count || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("class mismatch: expected index %0d count %0d last %0d, got %0d %0d %0d",
                        e.index, e.count, e.last, index, count, last);
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_allele_bit = 1'b0;
   logic                        req_last_in_line = 1'b0;
   logic                        req_last_in_sample = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [sfs_pkg::CLASS_W-1:0] rsp_class_index;
   logic [sfs_pkg::COUNT_W-1:0] rsp_class_count;
   logic                        rsp_last_class;
   logic                        csr_wr_en = 1'b0;
   logic                        csr_wr_data = 1'b0;

   sfs_tally    tally = new();
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned idle_run = 0;

   site_frequency_spectrum dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_allele_bit     (req_allele_bit),
      .req_last_in_line   (req_last_in_line),
      .req_last_in_sample (req_last_in_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_class_index    (rsp_class_index),
      .rsp_class_count    (rsp_class_count),
      .rsp_last_class     (rsp_last_class),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall)
         tally.check_class(rsp_class_index, rsp_class_count, rsp_last_class);
   end

   initial begin
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_run = 0;
         else idle_run++;
      end
      $display("[site_frequency_spectrum] ERROR");
      $finish;
   end

   task automatic send_item(input logic allele, input logic eol, input logic eos);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_allele_bit     <= allele;
      req_last_in_line   <= eol;
      req_last_in_sample <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tally.note_item(allele, eol, eos);
      items_sent++;
   endtask

   // ragged: later lines take random lengths around the first one
   task automatic send_sample(input int unsigned lines, input int unsigned first_len,
                              input int unsigned rest_len, input bit ragged);
      int unsigned share [];
      int unsigned len;
      bit          final_line;
      share = new[first_len + 4];
      foreach (share[j]) begin
         case ($urandom_range(3))
            0: share[j] = 0;
            1: share[j] = 100;
            default: share[j] = $urandom_range(100);
         endcase
      end
      for (int unsigned l = 0; l < lines; l++) begin
         len = (l == 0) ? first_len : rest_len;
         if (ragged && l != 0) len = $urandom_range(1, first_len + 3);
         final_line = (l == lines - 1);
         for (int unsigned j = 0; j < len; j++) begin
            if (j != len - 1)
               send_item($urandom_range(99) < share[j], 1'b0, 1'b0);
            else if (final_line)
               send_item($urandom_range(99) < share[j], 1'($urandom_range(1)), 1'b1);
            else
               send_item($urandom_range(99) < share[j], 1'b1, 1'b0);
         end
      end
   endtask

   task automatic send_noise(input int unsigned total);
      for (int unsigned k = 0; k < total; k++) begin
         if (k == total - 1)
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
         else
            send_item(1'($urandom_range(1)), $urandom_range(4) == 0, 1'b0);
      end
   endtask

   task automatic send_random_sample();
      int unsigned lines;
      int unsigned sites;
      lines = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 9);
      sites = $urandom_range(1, 12);
      case ($urandom_range(9))
         9: send_noise($urandom_range(4, 40));
         8: send_sample(lines, sites, sites, 1'b1);
         default: send_sample(lines, sites, sites, 1'b0);
      endcase
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (tally.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fold(input bit fold);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fold;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tally.fold = fold;
   endtask

   initial begin
      int unsigned start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_fold(1'b0);
      // single line: no classes
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b0, 1'b0, 1'b1);
      // three lines, the second too long, the third too short
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b0, 1'b0, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b0, 1'b0, 1'b1);

      set_fold(1'b1);
      // even n fold: middle class kept single
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b0, 1'b1, 1'b0);
      send_item(1'b1, 1'b0, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b0, 1'b0, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b0, 1'b0, 1'b0);
      send_item(1'b0, 1'b0, 1'b1);
      // odd n fold
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b1, 1'b1, 1'b0);
      send_item(1'b0, 1'b1, 1'b0);
      send_item(1'b0, 1'b1, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               set_fold(1'b0);
               gap_pct = 51;
               stall_pct = 0;
               send_sample(66, 1, 1, 1'b0);
            end
            1: begin
               set_fold(1'b1);
               gap_pct = 0;
               stall_pct = 51;
               send_sample(3, 8, 6, 1'b0);
            end
            2: begin
               set_fold(1'b1);
               gap_pct = 24;
               stall_pct = 24;
               send_sample(65, 1, 1, 1'b0);
            end
            default: begin
               set_fold(1'b0);
               gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         start = items_sent;
         while (items_sent - start < ITEMS_PER_PHASE) send_random_sample();
      end

      wait_drain();
      if (tally.mismatches == 0 && tally.pending.size() == 0)
         $display("[site_frequency_spectrum] OK");
      else
         $display("[site_frequency_spectrum] ERROR");
      $finish;
   end

endmodule
